[src/mrrm_pkg.sv]
// Shared types, constants and frame helper for the Modbus read-register master.
package mrrm_pkg;

  // Input kinds carried in tuser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_RX    = 1'b1;

  // Result kinds carried in tuser
  typedef enum logic {
    RK_TX      = 1'b0,
    RK_READING = 1'b1
  } mrrm_rkind_e;

  // Classified operation held in the queue
  typedef enum logic {
    OP_START = 1'b0,
    OP_RX    = 1'b1
  } mrrm_op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_SEND
  } mrrm_state_e;

  // Register indexes on the config port
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_REG_ADDR   = 1'b1;

  // Protocol constants
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HR  = 8'h03;
  localparam logic [15:0] READ_COUNT    = 16'h0001;
  localparam logic [7:0]  REPLY_NBYTES  = 8'h02;
  localparam logic [2:0]  CRC_LAST_BYTE = 3'd5;
  localparam logic [2:0]  FRAME_LAST    = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    mrrm_op_e   op;
    logic [7:0] data;
  } mrrm_entry_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic        valid;
    mrrm_entry_t entry;
  } mrrm_head_t;

  // Request frame byte at a given position
  function automatic logic [7:0] frame_byte(input logic [2:0]  idx,
                                            input logic [7:0]  slave,
                                            input logic [15:0] reg_addr,
                                            input logic [15:0] crc);
    logic [7:0] b;
    case (idx)
      3'd0:    b = slave;
      3'd1:    b = FUNC_READ_HR;
      3'd2:    b = reg_addr[15:8];
      3'd3:    b = reg_addr[7:0];
      3'd4:    b = READ_COUNT[15:8];
      3'd5:    b = READ_COUNT[7:0];
      3'd6:    b = crc[7:0];
      default: b = crc[15:8];
    endcase
    return b;
  endfunction

endpackage

[src/mrrm_front.sv]
// Front end: accepts input beats, classifies them and queues them for the back end.
module mrrm_front import mrrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic       s_tuser_i,   // kind
  input  logic [7:0] s_tdata_i,   // rx_byte
  input  logic       pop_i,
  output mrrm_head_t head_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  mrrm_entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic                 push;
  mrrm_entry_t          new_entry;

  // Classify the incoming beat
  always_comb begin
    new_entry.op   = (s_tuser_i == KIND_RX) ? OP_RX : OP_START;
    new_entry.data = s_tdata_i;
  end

  assign s_tready_o   = (fill_q != CntW'(QUEUE_DEPTH));
  assign push         = s_tvalid_i && s_tready_o;
  assign head_o.valid = (fill_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop_i) begin
      fill_d = fill_q + CntW'(1);
    end else if (!push && pop_i) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

`ifndef SYNTHESIS
  // Back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("pop from empty queue");
`endif

endmodule

[src/mrrm_back.sv]
// Back end: builds request frames with a bit-serial CRC and parses reply bytes.
module mrrm_back import mrrm_pkg::*; #(
  parameter int unsigned REPLY_LENGTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  mrrm_head_t  head_i,
  output logic        pop_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic        m_tuser_o,
  output logic        m_tlast_o,
  output logic [31:0] m_tdata_o
);

  localparam int unsigned CntW = $clog2(REPLY_LENGTH);
  localparam logic [CntW-1:0] LastCnt = CntW'(REPLY_LENGTH - 1);

  mrrm_state_e     state_q, state_d;
  logic [2:0]      idx_q, idx_d;
  logic [2:0]      bit_q, bit_d;
  logic [15:0]     crc_q, crc_d;
  logic            awaiting_q, awaiting_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [7:0]      val_hi_q, val_hi_d;
  logic [15:0]     new_val_q, new_val_d;
  logic [15:0]     last_good_q, last_good_d;
  logic [7:0]      slave_q;
  logic [15:0]     reg_addr_q;

  logic            o_valid_q, o_valid_d;
  mrrm_rkind_e     o_kind_q, o_kind_d;
  logic [7:0]      o_tx_q, o_tx_d;
  logic            o_last_q, o_last_d;
  logic [15:0]     o_rd_q, o_rd_d;
  logic            o_rv_q, o_rv_d;

  logic            slot_free;
  logic            rx_pop;
  logic [15:0]     crc_in;
  logic [7:0]      cur_byte;

  assign slot_free = !o_valid_q || m_tready_i;
  assign cur_byte  = frame_byte(idx_q, slave_q, reg_addr_q, crc_q);
  assign rx_pop    = pop_o && (head_i.entry.op == OP_RX);

  // Take an item only when idle and the output slot can take a reading
  assign pop_o = (state_q == ST_IDLE) && head_i.valid && slot_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && head_i.entry.op == OP_START) state_d = ST_CRC;
      end
      ST_CRC: begin
        if (idx_q == CRC_LAST_BYTE && bit_q == 3'd7) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (slot_free && idx_q == FRAME_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    idx_d       = idx_q;
    bit_d       = bit_q;
    crc_d       = crc_q;
    awaiting_d  = awaiting_q;
    cnt_d       = cnt_q;
    hdr_ok_d    = hdr_ok_q;
    val_hi_d    = val_hi_q;
    new_val_d   = new_val_q;
    last_good_d = last_good_q;
    o_valid_d   = slot_free ? 1'b0 : o_valid_q;
    o_kind_d    = o_kind_q;
    o_tx_d      = o_tx_q;
    o_last_d    = o_last_q;
    o_rd_d      = o_rd_q;
    o_rv_d      = o_rv_q;
    crc_in      = (bit_q == 3'd0) ? (crc_q ^ {8'h00, cur_byte}) : crc_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_o && head_i.entry.op == OP_START) begin
          // start: restart reply collection and CRC
          idx_d      = '0;
          bit_d      = '0;
          crc_d      = CRC_INIT;
          awaiting_d = 1'b1;
          cnt_d      = '0;
          hdr_ok_d   = 1'b1;
        end else if (rx_pop && awaiting_q) begin
          // reply byte: header check and value capture
          case (cnt_q)
            CntW'(0): if (head_i.entry.data != slave_q)      hdr_ok_d = 1'b0;
            CntW'(1): if (head_i.entry.data != FUNC_READ_HR) hdr_ok_d = 1'b0;
            CntW'(2): if (head_i.entry.data != REPLY_NBYTES) hdr_ok_d = 1'b0;
            CntW'(3): val_hi_d = head_i.entry.data;
            CntW'(4): new_val_d = {val_hi_q, head_i.entry.data};
            default: ;
          endcase
          if (cnt_q == LastCnt) begin
            awaiting_d = 1'b0;
            cnt_d      = '0;
            hdr_ok_d   = 1'b1;
            o_valid_d  = 1'b1;
            o_kind_d   = RK_READING;
            o_tx_d     = '0;
            o_last_d   = 1'b0;
            if (hdr_ok_q) begin
              last_good_d = new_val_d;
              o_rd_d      = new_val_d;
              o_rv_d      = 1'b1;
            end else begin
              o_rd_d = last_good_q;
              o_rv_d = 1'b0;
            end
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      ST_CRC: begin
        // one shift of the reflected CRC per cycle
        crc_d = crc_in[0] ? ((crc_in >> 1) ^ CRC_POLY) : (crc_in >> 1);
        bit_d = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          idx_d = (idx_q == CRC_LAST_BYTE) ? 3'd0 : idx_q + 3'd1;
        end
      end
      ST_SEND: begin
        if (slot_free) begin
          o_valid_d = 1'b1;
          o_kind_d  = RK_TX;
          o_tx_d    = cur_byte;
          o_last_d  = (idx_q == FRAME_LAST);
          o_rd_d    = '0;
          o_rv_d    = 1'b0;
          idx_d     = idx_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      bit_q       <= '0;
      crc_q       <= CRC_INIT;
      awaiting_q  <= 1'b0;
      cnt_q       <= '0;
      hdr_ok_q    <= 1'b1;
      val_hi_q    <= '0;
      new_val_q   <= '0;
      last_good_q <= '0;
      o_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      crc_q       <= crc_d;
      awaiting_q  <= awaiting_d;
      cnt_q       <= cnt_d;
      hdr_ok_q    <= hdr_ok_d;
      val_hi_q    <= val_hi_d;
      new_val_q   <= new_val_d;
      last_good_q <= last_good_d;
      o_valid_q   <= o_valid_d;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q    <= 8'd1;
      reg_addr_q <= 16'd261;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SLAVE_ADDR) slave_q    <= cfg_data_i[7:0];
      if (cfg_index_i == CFG_REG_ADDR)   reg_addr_q <= cfg_data_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    o_kind_q <= o_kind_d;
    o_tx_q   <= o_tx_d;
    o_last_q <= o_last_d;
    o_rd_q   <= o_rd_d;
    o_rv_q   <= o_rv_d;
  end

  assign m_tvalid_o = o_valid_q;
  assign m_tuser_o  = o_kind_q;
  assign m_tlast_o  = o_last_q;
  assign m_tdata_o  = {7'd0, o_rv_q, o_rd_q, o_tx_q};

`ifndef SYNTHESIS
  // Frame transmission only follows a start, which arms reply collection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) |-> awaiting_q)
    else $error("sending frame without pending reply");
  // Reply counter rests at zero outside a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !awaiting_q |-> (cnt_q == '0))
    else $error("reply count nonzero while not awaiting");
  // Last flag only on transmit beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_last_q) |-> (o_kind_q == RK_TX))
    else $error("last flag on a reading beat");
  // A finished CRC pass always enters the send phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC && idx_q == CRC_LAST_BYTE && bit_q == 3'd7) |=> (state_q == ST_SEND))
    else $error("CRC pass did not hand over to send");
`endif

endmodule

[src/modbus_read_register_master.sv]
// Top level of the Modbus RTU master that reads one holding register.
//
//  channel  | dir | handshake           | payload
//  s_axis   | in  | tvalid/tready       | tuser=kind, tdata[7:0]=rx_byte
//  m_axis   | out | tvalid/tready/tlast | tuser=result_kind, tdata=tx_byte/reading/valid
//  cfg      | in  | we, no wait         | index 0 slave_address, 1 register_address
//
// A start beat is popped, then the bit-serial CRC runs over six bytes (one shift per cycle)
// and the eight frame bytes are sent one by one as the output register frees.
// A received byte is handled when popped; a reading leaves on the last reply byte.
// A two-beat queue separates input acceptance from the back end; the output register
// takes a new beat in the same cycle the previous one is taken.
// Reset is asynchronous, active low; no clearing pass is needed.
module modbus_read_register_master import mrrm_pkg::*; #(
  parameter int unsigned REPLY_LENGTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic        s_axis_tuser_i,   // kind
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic        m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o,   // last_byte
  output logic [31:0] m_axis_tdata_o    // [7:0] tx_byte, [23:8] reading, [24] reading_valid
);

  mrrm_head_t head;
  logic       pop;

  mrrm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tdata_i  (s_axis_tdata_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  mrrm_back #(
    .REPLY_LENGTH (REPLY_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

[tb/sv/modbus_read_register_master_test.sv]
// Self-checking testbench for the Modbus read-register master: stream driver, monitor, predictor.
module modbus_read_register_master_test;
  import mrrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPLY_BYTES = 8;
  localparam int MAX_REPORTS = 10;

  // One input beat: kind in tuser, received byte in tdata
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rtu_item_t;

  // One output beat, split into its fields
  typedef struct packed {
    mrrm_rkind_e rkind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [15:0] reading;
    logic        reading_ok;
  } rtu_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_SLAVE_ADDR;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic        s_axis_tuser_i = KIND_START;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic [31:0] m_axis_tdata_o;

  // Pending input beats and expected output beats
  rtu_item_t stim_q[$];
  rtu_beat_t expected_beats[$];
  int        mismatches = 0;

  // Traffic shaping controls; steady and stall_req are written by the sequence at the falling edge
  logic steady = 1'b0;
  logic stall_req = 1'b0;
  logic stall_taken = 1'b0;
  int   stall_left = 0;

  // Predictor state
  logic [7:0]  cfg_slave = 8'd1;
  logic [15:0] cfg_reg = 16'd261;
  logic        rx_waiting = 1'b0;
  logic [3:0]  rx_pos = '0;
  logic        hdr_ok = 1'b1;
  logic [7:0]  val_hi = '0;
  logic [15:0] val_new = '0;
  logic [15:0] val_good = '0;

  // Generator's view of where the reply stands
  logic gen_waiting = 1'b0;
  int   gen_pos = 0;

  modbus_read_register_master #(
    .REPLY_LENGTH(REPLY_BYTES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Modbus CRC-16, one byte, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Expected beats for one accepted input beat
  task automatic predict_master(input logic kind, input logic [7:0] b);
    logic [7:0]  frame[8];
    logic [15:0] crc;
    rtu_beat_t   beat;
    if (kind == KIND_START) begin
      frame[0] = cfg_slave;
      frame[1] = FUNC_READ_HR;
      frame[2] = cfg_reg[15:8];
      frame[3] = cfg_reg[7:0];
      frame[4] = READ_COUNT[15:8];
      frame[5] = READ_COUNT[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc16_update(crc, frame[i]);
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int i = 0; i < 8; i++) begin
        beat = '{rkind: RK_TX, tx_byte: frame[i], last_byte: (i == 7), reading: 16'h0000,
                 reading_ok: 1'b0};
        expected_beats.push_back(beat);
      end
      rx_waiting = 1'b1;
      rx_pos = '0;
      hdr_ok = 1'b1;
    end else if (rx_waiting) begin
      case (rx_pos)
        4'd0: if (b != cfg_slave) hdr_ok = 1'b0;
        4'd1: if (b != FUNC_READ_HR) hdr_ok = 1'b0;
        4'd2: if (b != REPLY_NBYTES) hdr_ok = 1'b0;
        4'd3: val_hi = b;
        4'd4: val_new = {val_hi, b};
        default: ;
      endcase
      if (rx_pos >= REPLY_BYTES - 1) begin
        if (hdr_ok) val_good = val_new;
        beat = '{rkind: RK_READING, tx_byte: 8'h00, last_byte: 1'b0,
                 reading: hdr_ok ? val_new : val_good, reading_ok: hdr_ok};
        expected_beats.push_back(beat);
        rx_waiting = 1'b0;
        rx_pos = '0;
        hdr_ok = 1'b1;
      end else begin
        rx_pos = rx_pos + 4'd1;
      end
    end
  endtask

  // Input driver: holds a beat until taken, idles at random between beats unless steady
  always @(posedge clk_i) begin : drive_input
    rtu_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_master(s_axis_tuser_i, s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (stim_q.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
          nxt = stim_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= nxt.kind;
          s_axis_tdata_i  <= nxt.data;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the sequence
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_req && !stall_taken) begin
      stall_left  <= 400;
      stall_taken <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Output ready: random backpressure unless steady, low during the hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady || ($urandom_range(99) >= 8);
    end
  end

  // Monitor: every output beat against the oldest expectation
  always @(posedge clk_i) begin : check_output
    rtu_beat_t got;
    rtu_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{rkind: mrrm_rkind_e'(m_axis_tuser_o), tx_byte: m_axis_tdata_o[7:0],
              last_byte: m_axis_tlast_o, reading: m_axis_tdata_o[23:8],
              reading_ok: m_axis_tdata_o[24]};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat kind=%0d tx=%02h last=%0d reading=%04h ok=%0d",
                   $realtime, got.rkind, got.tx_byte, got.last_byte, got.reading,
                   got.reading_ok);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: beat mismatch exp kind=%0d tx=%02h last=%0d reading=%04h ok=%0d%s",
                     $realtime, want.rkind, want.tx_byte, want.last_byte, want.reading,
                     want.reading_ok,
                     $sformatf(" got kind=%0d tx=%02h last=%0d reading=%04h ok=%0d",
                               got.rkind, got.tx_byte, got.last_byte, got.reading,
                               got.reading_ok));
        end
      end
    end
  end

  task automatic push_item(input logic kind, input logic [7:0] data);
    rtu_item_t it;
    it = '{kind: kind, data: data};
    stim_q.push_back(it);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SLAVE_ADDR) cfg_slave = value[7:0];
    else cfg_reg = value;
  endtask

  // Wait until all beats are taken and all results are in, then let the block settle
  task automatic wait_drained(input int settle);
    while (stim_q.size() != 0 || s_axis_tvalid_i || expected_beats.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Mostly well-formed request/reply exchanges, with restarts, noise and bad headers
  task automatic gen_traffic(input int n);
    int         counted;
    int         r;
    logic [7:0] b;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(99);
      if (!gen_waiting) begin
        if (r < 25) begin
          push_item(KIND_RX, 8'($urandom_range(255)));
        end else begin
          push_item(KIND_START, 8'($urandom_range(255)));
          gen_waiting = 1'b1;
          gen_pos = 0;
          counted++;
        end
      end else if (r < 3) begin
        push_item(KIND_START, 8'($urandom_range(255)));
        gen_pos = 0;
        counted++;
      end else begin
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(255));
        endcase
        if (gen_pos == 0) b = cfg_slave;
        else if (gen_pos == 1) b = FUNC_READ_HR;
        else if (gen_pos == 2) b = REPLY_NBYTES;
        if (gen_pos < 3 && r >= 90) b = b ^ 8'($urandom_range(1, 255));
        if (r < 6) b = 8'($urandom_range(255));
        push_item(KIND_RX, b);
        gen_pos++;
        counted++;
        if (gen_pos == REPLY_BYTES) gen_waiting = 1'b0;
      end
    end
  endtask

  // Main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: stray byte, good reply, stray byte, restart mid-reply, wrong address
    push_item(KIND_RX, 8'h00);
    push_item(KIND_START, 8'h00);
    push_item(KIND_RX, 8'h01);
    push_item(KIND_RX, FUNC_READ_HR);
    push_item(KIND_RX, REPLY_NBYTES);
    push_item(KIND_RX, 8'hFF);
    push_item(KIND_RX, 8'hFF);
    push_item(KIND_RX, 8'h00);
    push_item(KIND_RX, 8'hFF);
    push_item(KIND_RX, 8'h00);
    push_item(KIND_RX, 8'hAA);
    push_item(KIND_START, 8'hFF);
    push_item(KIND_RX, 8'h01);
    push_item(KIND_RX, FUNC_READ_HR);
    push_item(KIND_RX, REPLY_NBYTES);
    push_item(KIND_START, 8'h5A);
    push_item(KIND_RX, 8'h02);
    push_item(KIND_RX, FUNC_READ_HR);
    push_item(KIND_RX, REPLY_NBYTES);
    push_item(KIND_RX, 8'h12);
    push_item(KIND_RX, 8'h34);
    push_item(KIND_RX, 8'h00);
    push_item(KIND_RX, 8'h00);
    push_item(KIND_RX, 8'h00);
    wait_drained(20);

    // Lowest settings
    write_reg(CFG_SLAVE_ADDR, 16'h0000);
    write_reg(CFG_REG_ADDR, 16'h0000);
    @(negedge clk_i);
    gen_traffic(40);
    wait_drained(20);

    // Highest settings, receiver holds off while the sender keeps offering
    write_reg(CFG_SLAVE_ADDR, 16'h00FF);
    write_reg(CFG_REG_ADDR, 16'hFFFF);
    @(negedge clk_i);
    stall_req = 1'b1;
    gen_traffic(40);
    wait_drained(20);

    // Random settings, no idling on either side
    write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(255)));
    write_reg(CFG_REG_ADDR, 16'($urandom_range(65535)));
    @(negedge clk_i);
    steady = 1'b1;
    gen_traffic(40);
    wait_drained(20);

    // Random settings, random idling again
    write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(255)));
    write_reg(CFG_REG_ADDR, 16'($urandom_range(65535)));
    @(negedge clk_i);
    steady = 1'b0;
    gen_traffic(40);
    wait_drained(100);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("modbus_read_register_master_test passed");
    end else begin
      $display("modbus_read_register_master_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("modbus_read_register_master_test failed");
    $finish;
  end

endmodule
